// File: sv/deq_pkg.sv
// Shared types, codes and field widths of the double-ended queue
`timescale 1ns / 1ps

package deq_pkg;

  // field widths of the words on the two channels
  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // default sizing handed to the top level
  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;

  // operation codes, the two unused codes act as a query
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_POS   = 2'd3;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_READ,
    S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic shift_rd;
    logic shift_wr;
    logic ins_wr;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ins_go;
    logic shift_more;
    logic out_free;
  } stat_t;

endpackage

// File: sv/double_ended_queue_with_insert.sv
// Top level of the bounded double-ended queue with positional insert
//
//   channel  direction  handshake             word
//   in_      input      in_valid / in_ready   mode, value, position
//   out_     output     out_valid / out_ready front_word, back_word, entry_count, status
//
// Push, pop, query and a rejected insert go from acceptance through the update, a read of
// both end slots, then the load of the result register, which waits until that register frees.
// A stored insert first moves each later entry a place back, a read of a slot and then its
// write one further back, as the ring store has a single write port, then writes the new word.
// Reset clears the controller state, head, count and the output valid flag; the store needs no clearing pass.
// A result waits in the output register; one more word is taken meanwhile and
// its result is held back until the register frees.
`timescale 1ns / 1ps

module double_ended_queue_with_insert #(
  parameter int DEPTH     = deq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [deq_pkg::MODE_W-1:0]     in_mode,
  input  logic [deq_pkg::VALUE_W-1:0]    in_value,
  input  logic [deq_pkg::POS_W-1:0]      in_position,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [deq_pkg::VALUE_W-1:0]    out_front_word,
  output logic [deq_pkg::VALUE_W-1:0]    out_back_word,
  output logic [deq_pkg::COUNT_W-1:0]    out_entry_count,
  output logic [deq_pkg::STATUS_W-1:0]   out_status
);

  deq_pkg::cmd_t  cmd;
  deq_pkg::stat_t stat;

  // sequencer
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store and result register
  deq_dpath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .in_position     (in_position),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_front_word  (out_front_word),
    .out_back_word   (out_back_word),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

`ifndef SYNTHESIS
  // one word in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again before the operation finished");

  // an empty result reports no entries and zero ends
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == deq_pkg::STAT_EMPTY) |->
      (out_entry_count == '0 && out_front_word == '0 && out_back_word == '0))
    else $error("empty status with stored words or nonzero ends");

  // a push or insert rejected as full only happens at full capacity
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == deq_pkg::STAT_FULL) |->
      (out_entry_count == deq_pkg::COUNT_W'(DEPTH)))
    else $error("full status below capacity");
`endif

endmodule

// File: sv/deq_ctrl.sv
// Controller state machine of the double-ended queue
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  deq_pkg::stat_t stat,
  output deq_pkg::cmd_t  cmd
);

  deq_pkg::state_t state_r;
  deq_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      deq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.ins_go ? deq_pkg::S_SHIFT_RD : deq_pkg::S_READ;
        end
      end
      deq_pkg::S_SHIFT_RD: begin
        if (stat.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_nxt    = deq_pkg::S_SHIFT_WR;
        end else begin
          cmd.ins_wr = 1'b1;
          state_nxt  = deq_pkg::S_READ;
        end
      end
      deq_pkg::S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = deq_pkg::S_SHIFT_RD;
      end
      deq_pkg::S_READ: begin
        state_nxt = deq_pkg::S_RESP;
      end
      deq_pkg::S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = deq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/deq_dpath.sv
// Datapath of the double-ended queue: ring store, head and count, result register
`timescale 1ns / 1ps

module deq_dpath #(
  parameter int DEPTH     = deq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [deq_pkg::MODE_W-1:0]     in_mode,
  input  logic [deq_pkg::VALUE_W-1:0]    in_value,
  input  logic [deq_pkg::POS_W-1:0]      in_position,
  input  deq_pkg::cmd_t                  cmd,
  output deq_pkg::stat_t                 stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [deq_pkg::VALUE_W-1:0]    out_front_word,
  output logic [deq_pkg::VALUE_W-1:0]    out_back_word,
  output logic [deq_pkg::COUNT_W-1:0]    out_entry_count,
  output logic [deq_pkg::STATUS_W-1:0]   out_status
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > deq_pkg::POS_W) ? CNT_W : deq_pkg::POS_W;
  localparam int OCW_W = (CNT_W > deq_pkg::COUNT_W) ? CNT_W : deq_pkg::COUNT_W;

  // ring slot of a place counted from a base slot
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] offs);
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;
    sum     = SUM_W'(base) + SUM_W'(offs);
    wrapped = (sum >= SUM_W'(DEPTH)) ? sum - SUM_W'(DEPTH) : sum;
    return wrapped[IDX_W-1:0];
  endfunction

  logic [WORD_BITS-1:0]           store_r [DEPTH];
  logic [WORD_BITS-1:0]           rd_a_r;
  logic [WORD_BITS-1:0]           rd_b_r;

  logic [IDX_W-1:0]               head_r, head_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [CNT_W-1:0]               k_r, k_nxt;
  logic [CNT_W-1:0]               pos_r, pos_nxt;
  logic [WORD_BITS-1:0]           word_r, word_nxt;
  logic [deq_pkg::STATUS_W-1:0]   status_r, status_nxt;

  logic                           out_valid_r;
  logic [deq_pkg::VALUE_W-1:0]    out_front_r, out_back_r;
  logic [deq_pkg::COUNT_W-1:0]    out_count_r;
  logic [deq_pkg::STATUS_W-1:0]   out_status_r;

  logic [63:0]                    value_ext;
  logic [WORD_BITS-1:0]           in_word;
  logic [CMP_W-1:0]               pos_cmp;
  logic                           pos_gt;
  logic                           full;
  logic                           empty;
  logic [IDX_W-1:0]               head_dec;
  logic [CNT_W-1:0]               back_offs;

  logic                           we;
  logic [IDX_W-1:0]               waddr;
  logic [WORD_BITS-1:0]           wdata;
  logic [IDX_W-1:0]               raddr_a;
  logic [IDX_W-1:0]               raddr_b;

  logic [63:0]                    front_ext;
  logic [63:0]                    back_ext;
  logic [OCW_W-1:0]               count_ext;

  // decode of the incoming word
  assign value_ext = 64'(in_value);
  assign in_word   = value_ext[WORD_BITS-1:0];
  assign pos_cmp   = CMP_W'(in_position);
  assign pos_gt    = pos_cmp > CMP_W'(count_r);
  assign full      = count_r == CNT_W'(DEPTH);
  assign empty     = count_r == '0;
  assign head_dec  = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
  assign back_offs = empty ? '0 : count_r - 1'b1;

  // status towards the controller
  assign stat.ins_go     = (in_mode == deq_pkg::MODE_INSERT) && !pos_gt && !full;
  assign stat.shift_more = k_r > pos_r;
  assign stat.out_free   = !out_valid_r || out_ready;

  // operation decode, write port and state update
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    pos_nxt    = pos_r;
    word_nxt   = word_r;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = slot_of(head_r, count_r);
    wdata      = in_word;
    if (cmd.accept) begin
      status_nxt = deq_pkg::STAT_DONE;
      case (in_mode)
        deq_pkg::MODE_PUSH_BACK: begin
          if (full) begin
            status_nxt = deq_pkg::STAT_FULL;
          end else begin
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        deq_pkg::MODE_PUSH_FRONT: begin
          if (full) begin
            status_nxt = deq_pkg::STAT_FULL;
          end else begin
            we        = 1'b1;
            waddr     = head_dec;
            head_nxt  = head_dec;
            count_nxt = count_r + 1'b1;
          end
        end
        deq_pkg::MODE_POP_BACK: begin
          if (empty) begin
            status_nxt = deq_pkg::STAT_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        deq_pkg::MODE_POP_FRONT: begin
          if (empty) begin
            status_nxt = deq_pkg::STAT_EMPTY;
          end else begin
            head_nxt  = slot_of(head_r, CNT_W'(1));
            count_nxt = count_r - 1'b1;
          end
        end
        deq_pkg::MODE_INSERT: begin
          if (pos_gt) begin
            status_nxt = deq_pkg::STAT_POS;
          end else if (full) begin
            status_nxt = deq_pkg::STAT_FULL;
          end else begin
            // position fits the count here, so the low bits hold it
            word_nxt = in_word;
            pos_nxt  = pos_cmp[CNT_W-1:0];
            k_nxt    = count_r;
          end
        end
        default: begin
          if (empty) begin
            status_nxt = deq_pkg::STAT_EMPTY;
          end
        end
      endcase
    end
    // move one later entry a place toward the back
    if (cmd.shift_wr) begin
      we    = 1'b1;
      waddr = slot_of(head_r, k_r);
      wdata = rd_a_r;
      k_nxt = k_r - 1'b1;
    end
    // drop the new word into the opened slot
    if (cmd.ins_wr) begin
      we        = 1'b1;
      waddr     = slot_of(head_r, pos_r);
      wdata     = word_r;
      count_nxt = count_r + 1'b1;
    end
  end

  // read addresses: shift source on port a, otherwise the two ends
  assign raddr_a = cmd.shift_rd ? slot_of(head_r, k_r - 1'b1) : head_r;
  assign raddr_b = slot_of(head_r, back_offs);

  // ring store, one write and two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
    rd_a_r <= store_r[raddr_a];
    rd_b_r <= store_r[raddr_b];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // operation payload registers
  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    pos_r    <= pos_nxt;
    word_r   <= word_nxt;
    status_r <= status_nxt;
  end

  // result word, ends read as zero when empty
  assign front_ext = empty ? 64'd0 : 64'(rd_a_r);
  assign back_ext  = empty ? 64'd0 : 64'(rd_b_r);
  assign count_ext = OCW_W'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_front_r  <= front_ext[deq_pkg::VALUE_W-1:0];
      out_back_r   <= back_ext[deq_pkg::VALUE_W-1:0];
      out_count_r  <= count_ext[deq_pkg::COUNT_W-1:0];
      out_status_r <= status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_word  = out_front_r;
  assign out_back_word   = out_back_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

endmodule

// File: tb/tb_double_ended_queue_with_insert.sv
// Self-checking testbench of the bounded double-ended queue with positional insert
`timescale 1ns / 1ps

module tb_double_ended_queue_with_insert;

  localparam int DEPTH = deq_pkg::DEPTH_DEF;
  // the two unused operation codes, both behave as a query
  localparam logic [deq_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [deq_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;
  localparam logic [deq_pkg::VALUE_W-1:0] WORD_ONES = {deq_pkg::VALUE_W{1'b1}};
  localparam logic [deq_pkg::POS_W-1:0] POS_ONES = {deq_pkg::POS_W{1'b1}};
  localparam int RANDOM_WORDS = 2000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1500000;

  // one result word as the block returns it
  typedef struct packed {
    logic [deq_pkg::VALUE_W-1:0]  front_word;
    logic [deq_pkg::VALUE_W-1:0]  back_word;
    logic [deq_pkg::COUNT_W-1:0]  entry_count;
    logic [deq_pkg::STATUS_W-1:0] status;
  } deque_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [deq_pkg::MODE_W-1:0]   in_mode;
  logic [deq_pkg::VALUE_W-1:0]  in_value;
  logic [deq_pkg::POS_W-1:0]    in_position;
  logic                         out_valid;
  logic                         out_ready;
  logic [deq_pkg::VALUE_W-1:0]  out_front_word;
  logic [deq_pkg::VALUE_W-1:0]  out_back_word;
  logic [deq_pkg::COUNT_W-1:0]  out_entry_count;
  logic [deq_pkg::STATUS_W-1:0] out_status;

  // shadow copy of the ring store
  logic [deq_pkg::VALUE_W-1:0] shadow_ring [DEPTH];
  int                          shadow_head;
  int                          shadow_count;

  deque_result_t pending_results [$];
  int            error_count;
  int            cycle_count;
  int            hold_request;
  bit            idle_on;

  double_ended_queue_with_insert dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_front_word  (out_front_word),
    .out_back_word   (out_back_word),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ring slot of a position counted from the front
  function automatic int ring_slot(input int idx);
    return (shadow_head + idx) % DEPTH;
  endfunction

  // apply one operation to the shadow deque and return its result word
  function automatic deque_result_t apply_deque_op(
    input logic [deq_pkg::MODE_W-1:0]  mode,
    input logic [deq_pkg::VALUE_W-1:0] word,
    input logic [deq_pkg::POS_W-1:0]   pos
  );
    deque_result_t res;
    logic [deq_pkg::STATUS_W-1:0] st;
    int k;
    st = deq_pkg::STAT_DONE;
    case (mode)
      deq_pkg::MODE_PUSH_BACK: begin
        if (shadow_count >= DEPTH) st = deq_pkg::STAT_FULL;
        else begin
          shadow_ring[ring_slot(shadow_count)] = word;
          shadow_count++;
        end
      end
      deq_pkg::MODE_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) st = deq_pkg::STAT_FULL;
        else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_head] = word;
          shadow_count++;
        end
      end
      deq_pkg::MODE_POP_BACK: begin
        if (shadow_count == 0) st = deq_pkg::STAT_EMPTY;
        else shadow_count--;
      end
      deq_pkg::MODE_POP_FRONT: begin
        if (shadow_count == 0) st = deq_pkg::STAT_EMPTY;
        else begin
          shadow_head = ring_slot(1);
          shadow_count--;
        end
      end
      deq_pkg::MODE_INSERT: begin
        // position check takes priority over the full check
        if (int'(pos) > shadow_count) st = deq_pkg::STAT_POS;
        else if (shadow_count >= DEPTH) st = deq_pkg::STAT_FULL;
        else begin
          for (k = shadow_count; k > int'(pos); k--)
            shadow_ring[ring_slot(k)] = shadow_ring[ring_slot(k - 1)];
          shadow_ring[ring_slot(int'(pos))] = word;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) st = deq_pkg::STAT_EMPTY;
      end
    endcase
    res.front_word  = (shadow_count > 0) ? shadow_ring[ring_slot(0)] : '0;
    res.back_word   = (shadow_count > 0) ? shadow_ring[ring_slot(shadow_count - 1)] : '0;
    res.entry_count = deq_pkg::COUNT_W'(shadow_count);
    res.status      = st;
    return res;
  endfunction

  // offer one word and wait for it to be taken, then maybe idle a while
  task automatic send_word(input logic [deq_pkg::MODE_W-1:0]  mode,
                           input logic [deq_pkg::VALUE_W-1:0] word,
                           input logic [deq_pkg::POS_W-1:0]   pos);
    int gap;
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_value    <= word;
    in_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_deque_op(mode, word, pos));
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait until every result has come back
  task automatic wait_for_drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // pops, queries and bad inserts on an empty deque
  task automatic test_empty_deque;
    send_word(deq_pkg::MODE_QUERY, WORD_ONES, POS_ONES);
    send_word(deq_pkg::MODE_POP_BACK, '0, '0);
    send_word(deq_pkg::MODE_POP_FRONT, WORD_ONES, '0);
    send_word(MODE_SPARE_A, '0, POS_ONES);
    send_word(MODE_SPARE_B, WORD_ONES, '0);
    send_word(deq_pkg::MODE_INSERT, 32'h1234_5678, 7'd1);
    send_word(deq_pkg::MODE_INSERT, 32'h8765_4321, POS_ONES);
    wait_for_drain();
  endtask

  // every operation at least once on a short deque, then pop it empty
  task automatic test_each_operation;
    send_word(deq_pkg::MODE_PUSH_BACK, WORD_ONES, POS_ONES);
    send_word(deq_pkg::MODE_PUSH_FRONT, '0, '0);
    send_word(deq_pkg::MODE_INSERT, 32'h5a5a_5a5a, '0);
    send_word(deq_pkg::MODE_INSERT, 32'ha5a5_a5a5, deq_pkg::POS_W'(shadow_count));
    send_word(deq_pkg::MODE_INSERT, 32'h0000_0001, 7'd2);
    send_word(deq_pkg::MODE_INSERT, 32'h8000_0000, deq_pkg::POS_W'(shadow_count + 1));
    send_word(deq_pkg::MODE_QUERY, '0, '0);
    send_word(MODE_SPARE_A, WORD_ONES, POS_ONES);
    send_word(MODE_SPARE_B, '0, '0);
    send_word(deq_pkg::MODE_POP_BACK, '0, '0);
    send_word(deq_pkg::MODE_POP_FRONT, '0, '0);
    send_word(deq_pkg::MODE_POP_FRONT, '0, '0);
    send_word(deq_pkg::MODE_POP_BACK, '0, '0);
    send_word(deq_pkg::MODE_POP_BACK, '0, '0);
    send_word(deq_pkg::MODE_POP_FRONT, '0, '0);
    send_word(deq_pkg::MODE_QUERY, '0, '0);
    wait_for_drain();
  endtask

  // fill to the brim behind a stalled receiver, overflow, then empty it
  task automatic test_fill_and_overflow;
    int n;
    hold_request = LONG_HOLD;
    for (n = 0; n < DEPTH; n++) begin
      if (n % 3 == 0)
        send_word(deq_pkg::MODE_PUSH_FRONT, $urandom(),
                  deq_pkg::POS_W'($urandom_range(0, 127)));
      else if (n % 3 == 1)
        send_word(deq_pkg::MODE_PUSH_BACK, $urandom(), '0);
      else
        send_word(deq_pkg::MODE_INSERT, $urandom(),
                  deq_pkg::POS_W'($urandom_range(0, shadow_count)));
    end
    send_word(deq_pkg::MODE_PUSH_BACK, WORD_ONES, '0);
    send_word(deq_pkg::MODE_PUSH_FRONT, '0, '0);
    send_word(deq_pkg::MODE_INSERT, 32'hdead_beef, deq_pkg::POS_W'(DEPTH));
    send_word(deq_pkg::MODE_INSERT, 32'hdead_beef, '0);
    send_word(deq_pkg::MODE_INSERT, 32'hdead_beef, deq_pkg::POS_W'(DEPTH + 1));
    send_word(deq_pkg::MODE_INSERT, 32'hdead_beef, POS_ONES);
    send_word(deq_pkg::MODE_QUERY, '0, '0);
    wait_for_drain();
    // empty from both ends
    for (n = 0; n < DEPTH + 2; n++)
      send_word(($urandom_range(0, 1) != 0) ? deq_pkg::MODE_POP_BACK : deq_pkg::MODE_POP_FRONT,
                $urandom(), deq_pkg::POS_W'($urandom_range(0, 127)));
    wait_for_drain();
  endtask

  // random mixes that drift the fill level up and down
  task automatic test_random_traffic(input int total);
    int sent;
    int chunk;
    int n;
    int push_share;
    int pick;
    logic [deq_pkg::MODE_W-1:0]  mode;
    logic [deq_pkg::VALUE_W-1:0] word;
    logic [deq_pkg::POS_W-1:0]   pos;
    sent = 0;
    while (sent < total) begin
      chunk = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0:       push_share = 70;
        1:       push_share = 45;
        default: push_share = 20;
      endcase
      // no idling at all towards the end
      idle_on = (total - sent > 300) && ($urandom_range(0, 3) != 0);
      for (n = 0; n < chunk && sent < total; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < push_share) begin
          pick = $urandom_range(0, 2);
          mode = (pick == 0) ? deq_pkg::MODE_PUSH_BACK :
                 (pick == 1) ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_INSERT;
        end else if (pick < push_share + (100 - push_share) * 4 / 5) begin
          mode = ($urandom_range(0, 1) != 0) ? deq_pkg::MODE_POP_BACK :
                                               deq_pkg::MODE_POP_FRONT;
        end else begin
          pick = $urandom_range(0, 5);
          mode = (pick == 0) ? MODE_SPARE_A : (pick == 1) ? MODE_SPARE_B : deq_pkg::MODE_QUERY;
        end
        pick = $urandom_range(0, 19);
        word = (pick == 0) ? '0 : (pick == 1) ? WORD_ONES : $urandom();
        // inserts mostly land inside the deque, a few anywhere
        pick = $urandom_range(0, 19);
        if (mode != deq_pkg::MODE_INSERT || pick == 0)
          pos = deq_pkg::POS_W'($urandom_range(0, 127));
        else if (pick == 1) pos = '0;
        else if (pick == 2) pos = deq_pkg::POS_W'(shadow_count);
        else pos = deq_pkg::POS_W'($urandom_range(0, shadow_count));
        send_word(mode, word, pos);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) wait_for_drain();
    end
    wait_for_drain();
  endtask

  // result receiver with random back-pressure and requested long stalls
  initial begin
    int burst;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        burst = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 8);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each returned word with the oldest prediction
  always @(posedge clk) begin : check_results
    deque_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result word: front %h back %h count %0d status %0d",
                   out_front_word, out_back_word, out_entry_count, out_status);
      end else begin
        want = pending_results.pop_front();
        if (out_front_word !== want.front_word || out_back_word !== want.back_word ||
            out_entry_count !== want.entry_count || out_status !== want.status) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: expected front %h back %h count %0d status %0d",
                     want.front_word, want.back_word, want.entry_count, want.status);
            $display("          got      front %h back %h count %0d status %0d",
                     out_front_word, out_back_word, out_entry_count, out_status);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // reset, then the tests in turn
  initial begin
    in_valid     <= 1'b0;
    in_mode      <= deq_pkg::MODE_QUERY;
    in_value     <= '0;
    in_position  <= '0;
    rst_n        <= 1'b0;
    shadow_head  = 0;
    shadow_count = 0;
    error_count  = 0;
    hold_request = 0;
    idle_on      = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_deque();
    test_each_operation();
    test_fill_and_overflow();
    test_random_traffic(RANDOM_WORDS);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
